// File: rtl/core/lfpd_pkg.sv
// lfpd_pkg: shared types, widths, register indexes and the sensor position table
// for the line follow pd steering block. No dependencies.
package lfpd_pkg;

   localparam int unsigned GAIN_W  = 16;
   localparam int unsigned TRACK_W = 16;
   localparam int unsigned DERR_W  = TRACK_W + 1;
   // kp*err + kd*derr stays below 2^33 in magnitude
   localparam int unsigned PD_W    = 35;
   localparam int unsigned PROD_W  = GAIN_W + 1 + PD_W;
   localparam int unsigned FRAC_W  = 24;
   localparam int unsigned TURN_W  = PROD_W - FRAC_W;
   localparam int unsigned SUM_W   = TURN_W + 1;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_KP_GAIN      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KD_GAIN      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AMPLIFY_GAIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_SPEED   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DUTY     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LOST_STOP_MS = 3'd5;

   localparam logic [GAIN_W-1:0] KP_GAIN_RST      = 16'd2432;
   localparam logic [GAIN_W-1:0] KD_GAIN_RST      = 16'd1536;
   localparam logic [GAIN_W-1:0] AMPLIFY_GAIN_RST = 16'd1280;
   localparam logic [GAIN_W-1:0] BASE_SPEED_RST   = 16'd1650;
   localparam logic [GAIN_W-1:0] MAX_DUTY_RST     = 16'd10000;
   localparam logic [GAIN_W-1:0] LOST_STOP_MS_RST = 16'd500;

   typedef struct packed {
      logic        sensor_far_left;
      logic        sensor_near_left;
      logic        sensor_middle;
      logic        sensor_near_right;
      logic        sensor_far_right;
      logic [31:0] now_ms;
   } lfpd_req_type;

   typedef struct packed {
      logic [15:0] left_duty;
      logic [15:0] right_duty;
      logic        driving;
   } lfpd_rsp_type;

   // per request result of the sensor stage
   typedef struct packed {
      logic                      stop;
      logic signed [TRACK_W-1:0] err;
      logic signed [DERR_W-1:0]  derr;
   } lfpd_track_type;

   typedef struct packed {
      logic                   en;
      logic [GAIN_W-1:0]      gain;
      logic signed [PD_W-1:0] operand;
   } lfpd_mul_op_type;

   // weighted average * 256 / active count, truncated toward zero
   // index bits: far left, near left, middle, near right, far right
   function automatic logic signed [TRACK_W-1:0] track_pos(input logic [4:0] idx);
      logic signed [TRACK_W-1:0] pos;
      case (idx)
         5'b00001: pos = 16'sd23040;
         5'b00010: pos = 16'sd6400;
         5'b00011: pos = 16'sd14720;
         5'b00101: pos = 16'sd11520;
         5'b00110: pos = 16'sd3200;
         5'b00111: pos = 16'sd9813;
         5'b01000: pos = -16'sd6400;
         5'b01001: pos = 16'sd8320;
         5'b01011: pos = 16'sd7680;
         5'b01100: pos = -16'sd3200;
         5'b01101: pos = 16'sd5546;
         5'b01111: pos = 16'sd5760;
         5'b10000: pos = -16'sd23040;
         5'b10010: pos = -16'sd8320;
         5'b10011: pos = 16'sd2133;
         5'b10100: pos = -16'sd11520;
         5'b10110: pos = -16'sd5546;
         5'b10111: pos = 16'sd1600;
         5'b11000: pos = -16'sd14720;
         5'b11001: pos = -16'sd2133;
         5'b11010: pos = -16'sd7680;
         5'b11100: pos = -16'sd9813;
         5'b11101: pos = -16'sd1600;
         5'b11110: pos = -16'sd5760;
         default:  pos = 16'sd0;
      endcase
      return pos;
   endfunction

endpackage

// File: rtl/core/lfpd_mul.sv
// lfpd_mul: shared gain multiplier, unsigned gain times signed operand,
// product registered. Depends on lfpd_pkg.
module lfpd_mul (
   input  logic                                   clock,
   input  lfpd_pkg::lfpd_mul_op_type              op,
   output logic signed [lfpd_pkg::PROD_W-1:0]     prod
);
   import lfpd_pkg::*;

   logic signed [GAIN_W:0]   gain_s;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;

   assign gain_s  = $signed({1'b0, op.gain});
   assign prod_in = gain_s * op.operand;

   always_ff @(posedge clock) begin
      if (op.en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

// File: rtl/core/lfpd_track.sv
// lfpd_track: sensor position lookup, held track, lost-line timer and
// previous error; registers err/derr/stop per request. Depends on lfpd_pkg.
module lfpd_track (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  lfpd_pkg::lfpd_req_type req,
   input  logic [15:0]            lost_stop_ms,
   output lfpd_pkg::lfpd_track_type track
);
   import lfpd_pkg::*;

   logic [4:0]                sensors;
   logic                      any_line;
   logic signed [TRACK_W-1:0] table_pos;
   logic signed [TRACK_W-1:0] err;
   logic [31:0]               elapsed;
   logic                      stop;

   logic signed [TRACK_W-1:0] held_ff, held_in;
   logic signed [TRACK_W-1:0] prev_ff, prev_in;
   logic                      lost_ff, lost_in;
   logic [31:0]               start_ff, start_in;
   lfpd_track_type            track_ff, track_in;

   assign sensors   = {req.sensor_far_left, req.sensor_near_left, req.sensor_middle,
                       req.sensor_near_right, req.sensor_far_right};
   assign any_line  = |sensors;
   assign table_pos = track_pos(sensors);
   assign err       = any_line ? table_pos : held_ff;
   // first missing request starts the timer at its own timestamp
   assign elapsed   = req.now_ms - (lost_ff ? start_ff : req.now_ms);
   assign stop      = !any_line && (elapsed >= {16'd0, lost_stop_ms});

   always_comb begin
      held_in  = held_ff;
      prev_in  = prev_ff;
      lost_in  = lost_ff;
      start_in = start_ff;
      track_in = track_ff;
      if (accept) begin
         if (any_line) begin
            held_in = table_pos;
            lost_in = 1'b0;
         end else if (!lost_ff) begin
            lost_in  = 1'b1;
            start_in = req.now_ms;
         end
         if (!stop) begin
            prev_in = err;
         end
         track_in.stop = stop;
         track_in.err  = err;
         track_in.derr = $signed({err[TRACK_W-1], err}) - $signed({prev_ff[TRACK_W-1], prev_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= '0;
         prev_ff  <= '0;
         lost_ff  <= 1'b0;
         start_ff <= '0;
      end else begin
         held_ff  <= held_in;
         prev_ff  <= prev_in;
         lost_ff  <= lost_in;
         start_ff <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      track_ff <= track_in;
   end

   assign track = track_ff;

endmodule

// File: rtl/core/line_follow_pd_steering.sv
// line_follow_pd_steering: top level, configuration registers, pd sequencer
// and result register. Depends on lfpd_pkg, lfpd_track, lfpd_mul.
//
//  channel   ports                              direction  payload
//  request   req_valid req_stall req_data        in         lfpd_req_type
//  result    rsp_valid rsp_stall rsp_data        out        lfpd_rsp_type
//  config    csr_wr_en csr_index csr_wr_data     in         16-bit register
//
// the track lookup is registered at acceptance; the result is loaded after six
// sequencer steps around the one 17x35 multiplier (kp*err, kd*derr, sum,
// amplify*pd, truncate, clamp); a timed-out lost line goes from the kp*err
// step straight to clamp. req_stall is high while the sequencer is busy, so a
// new request is taken only once the last result is loaded.
// the result register lets the next request start while a result is stalled.
// synchronous reset restores register defaults and clears the held track, previous error and lost-line state.
module line_follow_pd_steering (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  lfpd_pkg::lfpd_req_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output lfpd_pkg::lfpd_rsp_type              rsp_data,
   input  logic                                csr_wr_en,
   input  logic [lfpd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [15:0]                         csr_wr_data
);
   import lfpd_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_PROP, S_DERIV, S_SUM, S_AMP, S_ROUND, S_CLAMP
   } state_type;

   logic [15:0] kp_ff, kd_ff, amp_ff, base_ff, max_duty_ff, lost_stop_ff;

   state_type              state_ff, state_in;
   logic signed [PD_W-1:0] acc_ff, acc_in;
   logic signed [TURN_W-1:0] turn_ff, turn_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   lfpd_rsp_type           rsp_ff, rsp_in;

   logic                     accept;
   logic                     load;
   lfpd_track_type           track;
   lfpd_mul_op_type          mul_op;
   logic signed [PROD_W-1:0] prod;
   logic [PROD_W-1:0]        rounded;
   logic signed [SUM_W-1:0]  base_s, turn_s, left_sum, right_sum;

   function automatic logic [15:0] clamp_duty(input logic signed [SUM_W-1:0] v,
                                              input logic [15:0] limit);
      logic [15:0] r;
      if (v > $signed({{(SUM_W-16){1'b0}}, limit})) begin
         r = limit;
      end else if (v < 0) begin
         r = 16'd0;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff        <= KP_GAIN_RST;
         kd_ff        <= KD_GAIN_RST;
         amp_ff       <= AMPLIFY_GAIN_RST;
         base_ff      <= BASE_SPEED_RST;
         max_duty_ff  <= MAX_DUTY_RST;
         lost_stop_ff <= LOST_STOP_MS_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_KP_GAIN:      kp_ff        <= csr_wr_data;
            CSR_KD_GAIN:      kd_ff        <= csr_wr_data;
            CSR_AMPLIFY_GAIN: amp_ff       <= csr_wr_data;
            CSR_BASE_SPEED:   base_ff      <= csr_wr_data;
            CSR_MAX_DUTY:     max_duty_ff  <= csr_wr_data;
            CSR_LOST_STOP_MS: lost_stop_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   lfpd_track u_track (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req          (req_data),
      .lost_stop_ms (lost_stop_ff),
      .track        (track)
   );

   always_comb begin
      mul_op = '0;
      case (state_ff)
         S_PROP: begin
            mul_op.en      = 1'b1;
            mul_op.gain    = kp_ff;
            mul_op.operand = {{(PD_W-TRACK_W){track.err[TRACK_W-1]}}, track.err};
         end
         S_DERIV: begin
            mul_op.en      = 1'b1;
            mul_op.gain    = kd_ff;
            mul_op.operand = {{(PD_W-DERR_W){track.derr[DERR_W-1]}}, track.derr};
         end
         S_AMP: begin
            mul_op.en      = 1'b1;
            mul_op.gain    = amp_ff;
            mul_op.operand = acc_ff;
         end
         default: ;
      endcase
   end

   lfpd_mul u_mul (
      .clock (clock),
      .op    (mul_op),
      .prod  (prod)
   );

   // truncate toward zero: bias negative products before dropping the fraction
   assign rounded   = prod + (prod[PROD_W-1] ? {{(PROD_W-FRAC_W){1'b0}}, {FRAC_W{1'b1}}}
                                             : {PROD_W{1'b0}});
   assign base_s    = $signed({{(SUM_W-16){1'b0}}, base_ff});
   assign turn_s    = $signed({turn_ff[TURN_W-1], turn_ff});
   assign left_sum  = base_s + turn_s;
   assign right_sum = base_s - turn_s;

   assign load = (state_ff == S_CLAMP) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      turn_in      = turn_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_PROP;
            end
         end
         S_PROP: begin
            state_in = track.stop ? S_CLAMP : S_DERIV;
         end
         S_DERIV: begin
            acc_in   = prod[PD_W-1:0];
            state_in = S_SUM;
         end
         S_SUM: begin
            acc_in   = acc_ff + prod[PD_W-1:0];
            state_in = S_AMP;
         end
         S_AMP: begin
            state_in = S_ROUND;
         end
         S_ROUND: begin
            turn_in  = $signed(rounded[PROD_W-1:FRAC_W]);
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               if (track.stop) begin
                  rsp_in = '0;
               end else begin
                  rsp_in.left_duty  = clamp_duty(left_sum, max_duty_ff);
                  rsp_in.right_duty = clamp_duty(right_sum, max_duty_ff);
                  rsp_in.driving    = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff  <= acc_in;
      turn_ff <= turn_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_PROP))
      else $error("accepted request did not start the sequencer");

   a_stop_skips_pd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROP && track.stop) |=> (state_ff == S_CLAMP))
      else $error("stopped request went through the pd steps");

   a_load_from_clamp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_CLAMP))
      else $error("result loaded outside the clamp step");

   a_stop_zero_duty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.driving) |->
         (rsp_ff.left_duty == 16'd0 && rsp_ff.right_duty == 16'd0))
      else $error("stopped result carries nonzero duty");

   a_duty_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.left_duty <= max_duty_ff && rsp_ff.right_duty <= max_duty_ff))
      else $error("duty above max_duty");
`endif

endmodule

// File: tb/line_follow_pd_steering_tb.sv
// line_follow_pd_steering_tb: self-checking bench for the pd steering block, with a
// random driver, monitor and scoreboard that predicts every result request.
// Depends on lfpd_pkg and the line_follow_pd_steering rtl.
module line_follow_pd_steering_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lfpd_pkg::*;

   // write indexes past the register list, the block must ignore them
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;
   localparam longint Q24_ONE = 64'sd16777216;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   lfpd_req_type         req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   lfpd_rsp_type         rsp_data;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [15:0]          csr_wr_data = '0;

   line_follow_pd_steering dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // steering state mirror
   logic [15:0]        kp_reg, kd_reg, amp_reg, base_reg, max_reg, lost_reg;
   logic signed [15:0] track_hold;
   logic signed [15:0] err_last;
   logic               line_lost;
   logic [31:0]        lost_since_ms;

   lfpd_req_type req_pending_q[$];
   lfpd_rsp_type duty_expect_q[$];
   int           mismatch_count = 0;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   logic [31:0]  tick_ms;
   lfpd_rsp_type duty_want;
   logic         duty_bad;

   function automatic lfpd_rsp_type steer_predict(lfpd_req_type r);
      int           wsum;
      int           active;
      logic [31:0]  elapsed;
      longint       err, derr, pd, prod, turn, left, right;
      lfpd_rsp_type res;
      wsum = 0;
      active = 0;
      if (r.sensor_far_left)   begin wsum -= 90; active++; end
      if (r.sensor_near_left)  begin wsum -= 25; active++; end
      if (r.sensor_middle)     begin active++; end
      if (r.sensor_near_right) begin wsum += 25; active++; end
      if (r.sensor_far_right)  begin wsum += 90; active++; end
      res = '0;
      if (active > 0) begin
         track_hold = 16'((wsum * 256) / active);
         line_lost = 1'b0;
      end else begin
         if (!line_lost) begin
            line_lost = 1'b1;
            lost_since_ms = r.now_ms;
         end
         elapsed = r.now_ms - lost_since_ms;
         // stopped: zero duty, derivative history untouched
         if (elapsed >= {16'h0, lost_reg})
            return res;
      end
      err  = track_hold;
      derr = err - longint'(err_last);
      pd   = longint'(kp_reg) * err + longint'(kd_reg) * derr;
      prod = longint'(amp_reg) * pd;
      turn = prod / Q24_ONE;
      left  = longint'(base_reg) + turn;
      right = longint'(base_reg) - turn;
      if (left > longint'(max_reg)) left = max_reg;
      if (left < 0) left = 0;
      if (right > longint'(max_reg)) right = max_reg;
      if (right < 0) right = 0;
      res.left_duty  = 16'(left);
      res.right_duty = 16'(right);
      res.driving    = 1'b1;
      err_last = track_hold;
      return res;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            duty_expect_q.push_back(steer_predict(req_data));
         end
         if (!req_valid || !req_stall) begin
            if (req_pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data  <= req_pending_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset) begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         if (rsp_valid && !rsp_stall) begin
            if (duty_expect_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result: left %0d right %0d driving %0b",
                           rsp_data.left_duty, rsp_data.right_duty, rsp_data.driving);
            end else begin
               duty_want = duty_expect_q.pop_front();
               duty_bad = (rsp_data.left_duty != duty_want.left_duty) ||
                          (rsp_data.right_duty != duty_want.right_duty) ||
                          (rsp_data.driving != duty_want.driving);
               if (duty_bad) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("duty mismatch: expected %0d/%0d/%0b got %0d/%0d/%0b",
                              duty_want.left_duty, duty_want.right_duty,
                              duty_want.driving, rsp_data.left_duty,
                              rsp_data.right_duty, rsp_data.driving);
               end
            end
         end
      end
   end

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_KP_GAIN:      kp_reg = val;
         CSR_KD_GAIN:      kd_reg = val;
         CSR_AMPLIFY_GAIN: amp_reg = val;
         CSR_BASE_SPEED:   base_reg = val;
         CSR_MAX_DUTY:     max_reg = val;
         CSR_LOST_STOP_MS: lost_reg = val;
         default: ;
      endcase
   endtask

   task automatic steer_setup(input logic [15:0] kp, kd, amp, base, maxd, lost);
      csr_write(CSR_KP_GAIN, kp);
      csr_write(CSR_KD_GAIN, kd);
      csr_write(CSR_AMPLIFY_GAIN, amp);
      csr_write(CSR_BASE_SPEED, base);
      csr_write(CSR_MAX_DUTY, maxd);
      csr_write(CSR_LOST_STOP_MS, lost);
      @(negedge clock);
   endtask

   task automatic push_tick(input logic [4:0] sensors, input logic [31:0] now);
      lfpd_req_type it;
      it = '0;
      {it.sensor_far_left, it.sensor_near_left, it.sensor_middle,
       it.sensor_near_right, it.sensor_far_right} = sensors;
      it.now_ms = now;
      req_pending_q.push_back(it);
   endtask

   // runs of line seen and line lost with moving time, plus some noise
   task automatic push_random_ticks(input int n);
      int made;
      int run;
      int pick;
      int step_max;
      made = 0;
      while (made < n) begin
         pick = $urandom_range(99);
         run  = $urandom_range(1, 10);
         if (pick < 55) begin
            for (int i = 0; i < run && made < n; i++) begin
               tick_ms += $urandom_range(0, 40);
               push_tick(5'($urandom_range(1, 31)), tick_ms);
               made++;
            end
         end else if (pick < 92) begin
            case ($urandom_range(3))
               0: step_max = 2;
               1: step_max = 60;
               2: step_max = 1500;
               default: step_max = 70000;
            endcase
            for (int i = 0; i < run && made < n; i++) begin
               tick_ms += $urandom_range(0, step_max);
               push_tick(5'b00000, tick_ms);
               made++;
            end
         end else begin
            push_tick(5'($urandom_range(0, 31)), $urandom);
            made++;
         end
      end
   endtask

   // wait until every pending request is sent and every expected result is back
   task automatic drain_wait();
      while (req_pending_q.size() != 0 || req_valid || duty_expect_q.size() != 0)
         @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   initial begin
      kp_reg   = KP_GAIN_RST;
      kd_reg   = KD_GAIN_RST;
      amp_reg  = AMPLIFY_GAIN_RST;
      base_reg = BASE_SPEED_RST;
      max_reg  = MAX_DUTY_RST;
      lost_reg = LOST_STOP_MS_RST;
      track_hold    = '0;
      err_last      = '0;
      line_lost     = 1'b0;
      lost_since_ms = '0;
      tick_ms = 32'd100;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_idle_pct  = 10;
      recv_stall_pct = 54;

      // each sensor alone, symmetric and uneven groups
      push_tick(5'b10000, 32'd100);
      push_tick(5'b01000, 32'd110);
      push_tick(5'b00100, 32'd120);
      push_tick(5'b00010, 32'd130);
      push_tick(5'b00001, 32'd140);
      push_tick(5'b11111, 32'd150);
      push_tick(5'b10001, 32'd160);
      push_tick(5'b11000, 32'd170);
      push_tick(5'b00011, 32'd180);
      push_tick(5'b01110, 32'd190);
      push_tick(5'b10101, 32'd200);
      push_tick(5'b00111, 32'd210);
      // line lost: held track, then stop at the timeout boundary
      push_tick(5'b00000, 32'd1000);
      push_tick(5'b00000, 32'd1499);
      push_tick(5'b00000, 32'd1500);
      push_tick(5'b00000, 32'd9000);
      push_tick(5'b00100, 32'd9001);
      // lost across the timestamp wrap
      push_tick(5'b10000, 32'hFFFF_FFE0);
      push_tick(5'b00000, 32'hFFFF_FFF0);
      push_tick(5'b00000, 32'h0000_01E3);
      push_tick(5'b00000, 32'h0000_01E4);
      push_tick(5'b00001, 32'hFFFF_FFFF);
      push_tick(5'b00000, 32'h0000_0000);
      drain_wait();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            1: begin
               csr_write(CSR_SPARE_A, 16'h0000);
               steer_setup(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
               csr_write(CSR_SPARE_B, 16'h0001);
               @(negedge clock);
            end
            2: steer_setup(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
            4: steer_setup(16'hFFFF, 16'h0, 16'd256, 16'd32768, 16'hFFFF, 16'd1);
            3, 5: steer_setup(16'($urandom), 16'($urandom), 16'($urandom_range(0, 4000)),
                              16'($urandom), 16'($urandom),
                              16'($urandom_range(0, 3000)));
            default: ;
         endcase
         case (phase / 2)
            0: begin send_idle_pct = 10; recv_stall_pct = 54; end
            1: begin send_idle_pct = 54; recv_stall_pct = 10; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         if (phase % 2 == 1)
            tick_ms = 32'hFFFF_F000 + $urandom_range(0, 4095);
         push_random_ticks(140);
         drain_wait();
         push_random_ticks(135);
         drain_wait();
      end

      repeat (20) @(posedge clock);
      if (duty_expect_q.size() != 0)
         mismatch_count++;
      if (mismatch_count == 0)
         $display("line_follow_pd_steering verification clean");
      else
         $display("line_follow_pd_steering verification failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("line_follow_pd_steering verification failed");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/lfpd_pkg.sv
rtl/core/lfpd_mul.sv
rtl/core/lfpd_track.sv
rtl/core/line_follow_pd_steering.sv
tb/line_follow_pd_steering_tb.sv
